[design/fpd_pkg.sv]
package fpd_pkg;

  localparam int MAX_WORD_BYTES = 8;
  localparam int BYTE_W         = 8;
  localparam int WIN_IDX_W      = $clog2(MAX_WORD_BYTES);
  localparam int CNT_W          = $clog2(MAX_WORD_BYTES + 1);
  localparam int LEN_W          = 4;
  localparam int CFG_IDX_W      = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 1'b1;

  localparam logic [LEN_W-1:0] PATTERN_LENGTH_RST = 4'd1;

  typedef logic [MAX_WORD_BYTES-1:0][BYTE_W-1:0] byte_vec_t;

  // results produced by one input byte, handed to the output queue
  typedef struct packed {
    logic [CNT_W-1:0] count;
    byte_vec_t        bytes;
    logic             present;
    logic             final_word;
    logic             outcome;
  } fpd_batch_t;

endpackage

[design/first_pattern_delete_filter.sv]
// Deletes the first occurrence of a configured word (1 to 8 bytes) from a byte
// stream and passes every other byte through in order.
// Input channel: in_tdata carries one sentence byte, in_tlast marks the last
// byte of the sentence. Output channel: out_tdata carries the byte, out_tuser
// bit 0 says a byte is present, bit 1 gives the outcome on the last word
// (0 word deleted, 1 not found), out_tlast marks the sentence's last result.
// Configuration: cfg_index 0 writes the word (first byte in bits 7:0), index 1
// the word length; write only while the block holds no pending results.
// Latency: results of an input byte appear the cycle after it is accepted.
// Throughput: one input byte per cycle while each byte yields at most one
// result and out_tready is high; a byte that releases more keeps in_tready low
// until its last word is being taken, as the queue drains one word per cycle.
// When the receiver stalls, the output word holds and in_tready drops once
// the queue cannot take the next batch. Reset empties the window and the queue
// and sets the word to zero with length one.
module first_pattern_delete_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [fpd_pkg::BYTE_W-1:0]         in_tdata,   // data_byte
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [fpd_pkg::BYTE_W-1:0]         out_tdata,  // out_byte
  output logic [1:0]                         out_tuser,  // byte_present, outcome
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fpd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data
);

  fpd_pkg::byte_vec_t               pattern_r;
  logic [fpd_pkg::LEN_W-1:0]        len_r;
  fpd_pkg::fpd_batch_t              batch;
  logic                             accept;
  logic                             can_load;

  assign cfg_ready = 1'b1;
  assign in_tready = can_load;
  assign accept    = in_tvalid && can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      len_r     <= fpd_pkg::PATTERN_LENGTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpd_pkg::CFG_PATTERN_BYTES:  pattern_r <= cfg_data;
        fpd_pkg::CFG_PATTERN_LENGTH: len_r     <= cfg_data[fpd_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  fpd_window u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .in_byte     (in_tdata),
    .in_final    (in_tlast),
    .pattern     (pattern_r),
    .pattern_len (len_r),
    .batch       (batch)
  );

  fpd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .batch      (batch),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[design/fpd_window.sv]
module fpd_window (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              accept,
  input  logic [fpd_pkg::BYTE_W-1:0]        in_byte,
  input  logic                              in_final,
  input  fpd_pkg::byte_vec_t                pattern,
  input  logic [fpd_pkg::LEN_W-1:0]         pattern_len,
  output fpd_pkg::fpd_batch_t               batch
);

  fpd_pkg::byte_vec_t                win_r;
  fpd_pkg::byte_vec_t                win_nxt;
  logic [fpd_pkg::WIN_IDX_W-1:0]     fill_r;
  logic [fpd_pkg::WIN_IDX_W-1:0]     fill_nxt;
  logic                              deleted_r;
  logic                              deleted_nxt;

  fpd_pkg::byte_vec_t                comb_bytes;
  logic [fpd_pkg::CNT_W-1:0]         total;
  logic [fpd_pkg::CNT_W-1:0]         base;
  logic [fpd_pkg::CNT_W-1:0]         emit_cnt;
  logic [fpd_pkg::CNT_W-1:0]         retain_cnt;
  logic [fpd_pkg::WIN_IDX_W-1:0]     keep;
  logic                              can_match;
  logic                              hit;

  always_comb begin
    logic [fpd_pkg::CNT_W-1:0] idx;
    logic [fpd_pkg::CNT_W-1:0] src;
    idx = '0;
    src = '0;

    // held bytes with the new byte appended after them
    for (int i = 0; i < fpd_pkg::MAX_WORD_BYTES; i++) begin
      comb_bytes[i] = (fpd_pkg::WIN_IDX_W'(i) == fill_r) ? in_byte : win_r[i];
    end
    total = fpd_pkg::CNT_W'(fill_r) + fpd_pkg::CNT_W'(1);

    can_match = !deleted_r && (pattern_len != '0) &&
                (pattern_len <= fpd_pkg::LEN_W'(fpd_pkg::MAX_WORD_BYTES));
    keep = can_match ? fpd_pkg::WIN_IDX_W'(pattern_len - fpd_pkg::LEN_W'(1)) : '0;
    base = total - fpd_pkg::CNT_W'(pattern_len);

    // newest pattern_len bytes against the word
    hit = can_match && (total >= fpd_pkg::CNT_W'(pattern_len));
    for (int k = 0; k < fpd_pkg::MAX_WORD_BYTES; k++) begin
      if (fpd_pkg::LEN_W'(k) < pattern_len) begin
        idx = base + fpd_pkg::CNT_W'(k);
        if (comb_bytes[idx[fpd_pkg::WIN_IDX_W-1:0]] != pattern[k]) begin
          hit = 1'b0;
        end
      end
    end

    if (hit) begin
      emit_cnt = base;
    end else if (in_final) begin
      emit_cnt = total;
    end else if (total > fpd_pkg::CNT_W'(keep)) begin
      emit_cnt = total - fpd_pkg::CNT_W'(keep);
    end else begin
      emit_cnt = '0;
    end

    retain_cnt = (hit || in_final) ? '0 : (total - emit_cnt);

    // slide the kept bytes down to the front
    for (int i = 0; i < fpd_pkg::MAX_WORD_BYTES; i++) begin
      src = fpd_pkg::CNT_W'(i) + emit_cnt;
      if (src < fpd_pkg::CNT_W'(fpd_pkg::MAX_WORD_BYTES)) begin
        win_nxt[i] = comb_bytes[src[fpd_pkg::WIN_IDX_W-1:0]];
      end else begin
        win_nxt[i] = '0;
      end
    end

    fill_nxt    = retain_cnt[fpd_pkg::WIN_IDX_W-1:0];
    deleted_nxt = in_final ? 1'b0 : (deleted_r | hit);

    // an empty final step still gives one status word
    batch.count      = (in_final && emit_cnt == '0) ? fpd_pkg::CNT_W'(1) : emit_cnt;
    batch.bytes      = comb_bytes;
    batch.present    = (emit_cnt != '0);
    batch.final_word = in_final;
    batch.outcome    = !(deleted_r | hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      deleted_r <= 1'b0;
    end else if (accept) begin
      fill_r    <= fill_nxt;
      deleted_r <= deleted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

[design/fpd_outq.sv]
module fpd_outq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  fpd_pkg::fpd_batch_t            batch,
  output logic                           can_load,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fpd_pkg::BYTE_W-1:0]     out_tdata,
  output logic [1:0]                     out_tuser,
  output logic                           out_tlast
);

  logic [fpd_pkg::CNT_W-1:0] cnt_r;
  logic [fpd_pkg::CNT_W-1:0] cnt_nxt;
  fpd_pkg::byte_vec_t        q_r;
  fpd_pkg::byte_vec_t        q_nxt;
  logic                      present_r;
  logic                      final_r;
  logic                      outcome_r;
  logic                      pop;
  logic                      last_word;

  assign out_tvalid = (cnt_r != '0);
  assign pop        = out_tvalid && out_tready;
  assign last_word  = (cnt_r == fpd_pkg::CNT_W'(1));
  assign can_load   = (cnt_r == '0) || (last_word && out_tready);

  assign out_tdata    = present_r ? q_r[0] : '0;
  assign out_tlast    = final_r && last_word;
  assign out_tuser[0] = present_r;
  assign out_tuser[1] = out_tlast && outcome_r;

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt   = q_r;
    if (load && batch.count != '0) begin
      cnt_nxt = batch.count;
      q_nxt   = batch.bytes;
    end else if (pop) begin
      cnt_nxt = cnt_r - fpd_pkg::CNT_W'(1);
      for (int i = 0; i < fpd_pkg::MAX_WORD_BYTES - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      q_nxt[fpd_pkg::MAX_WORD_BYTES-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (load && batch.count != '0) begin
      present_r <= batch.present;
      final_r   <= batch.final_word;
      outcome_r <= batch.outcome;
    end
  end

endmodule
